// File: design/section_line_comment_filter_core_macros.svh
// Assertion macros used by the section line comment filter RTL
`ifndef SECTION_LINE_COMMENT_FILTER_CORE_MACROS_SVH
`define SECTION_LINE_COMMENT_FILTER_CORE_MACROS_SVH

// Check on every clock edge outside reset
`define SLCF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define SLCF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/slcf_pkg.sv
// Types and constants of the section line comment filter
`timescale 1ns / 1ps

package slcf_pkg;

	localparam int CHAR_W       = 8;
	localparam int NAME_W       = 128;
	localparam int NAME_LEN_W   = 5;
	localparam int TOKEN_POS_W  = 5;
	localparam int LINE_OUT_W   = 24;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_INDEX_W  = 2;
	localparam int FIFO_DEPTH   = 4;

	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
	localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;

	// "end", first letter at index 0
	localparam logic [2:0][CHAR_W-1:0] END_WORD = '{8'h64, 8'h6E, 8'h65};

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_NAME_LOW   = 2'd0,
		CFG_NAME_HIGH  = 2'd1,
		CFG_NAME_LEN   = 2'd2,
		CFG_FIRST_LINE = 2'd3
	} cfg_reg_e;

	typedef enum logic [1:0] {
		LC_CONTENT     = 2'd0,
		LC_SKIPPED     = 2'd1,
		LC_SECTION_END = 2'd2
	} line_class_e;

	typedef enum logic {
		ITEM_BYTE    = 1'b0,
		ITEM_SUMMARY = 1'b1
	} item_kind_e;

	typedef struct packed {
		logic                  item_kind;
		logic [CHAR_W-1:0]     char_out;
		logic [1:0]            line_class;
		logic [LINE_OUT_W-1:0] line_number;
		logic                  last_of_run;
	} slcf_res_t;

	typedef struct packed {
		logic [1:0] count;
		slcf_res_t  first;
		slcf_res_t  second;
	} slcf_push_t;

	typedef struct packed {
		logic [NAME_W-1:0]     name;
		logic [NAME_LEN_W-1:0] name_len;
		logic                  load_first;
		logic [LINE_OUT_W-1:0] first_line;
	} slcf_cfg_t;

endpackage

// File: design/slcf_in_if.sv
// Request channel interface of the section line comment filter
`timescale 1ns / 1ps

interface slcf_in_if import slcf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ch;
	logic              end_of_line;

	modport source (output valid, output ch, output end_of_line, input ready);
	modport sink (input valid, input ch, input end_of_line, output ready);
endinterface

// File: design/slcf_out_if.sv
// Result channel interface of the section line comment filter
`timescale 1ns / 1ps

interface slcf_out_if import slcf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  item_kind;
	logic [CHAR_W-1:0]     char_out;
	logic [1:0]            line_class;
	logic [LINE_OUT_W-1:0] line_number;
	logic                  last_of_run;

	modport source (output valid, output item_kind, output char_out, output line_class,
		output line_number, output last_of_run, input ready);
	modport sink (input valid, input item_kind, input char_out, input line_class,
		input line_number, input last_of_run, output ready);
endinterface

// File: design/slcf_parser.sv
// Per-line scanner: comment stripping, token match, line summary
`timescale 1ns / 1ps

module slcf_parser import slcf_pkg::*; #(
	parameter int LINE_NUMBER_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [CHAR_W-1:0] ch,
	input  logic              end_of_line,
	input  slcf_cfg_t         cfg,
	output slcf_push_t        push
);

	localparam logic [LINE_NUMBER_BITS-1:0] LINE_MAX = {LINE_NUMBER_BITS{1'b1}};
	localparam logic [TOKEN_POS_W-1:0] POS_MAX = {TOKEN_POS_W{1'b1}};

	logic                        at_start_q, at_start_n;
	logic                        pslash_q, pslash_n;
	logic                        in_lc_q, in_lc_n;
	logic                        in_bc_q, in_bc_n;
	logic                        star_q, star_n;
	logic                        skip_q, skip_n;
	logic [1:0]                  tc_q, tc_n;
	logic                        in_tok_q, in_tok_n;
	logic [TOKEN_POS_W-1:0]      pos_q, pos_n;
	logic                        fm_q, fm_n;
	logic                        sm_q, sm_n;
	logic                        lead_q, lead_n;
	logic [LINE_NUMBER_BITS-1:0] cnt_q, cnt_n;
	logic                        done_q, done_n;

	logic                        starting;
	logic [TOKEN_POS_W-1:0]      pos_e;
	logic [CHAR_W-1:0]           name_ch;
	logic [LINE_NUMBER_BITS+LINE_OUT_W-1:0] num_ext;
	logic [LINE_NUMBER_BITS+LINE_OUT_W-1:0] first_ext;
	line_class_e                 cls;

	function automatic logic is_lead_space(input logic [CHAR_W-1:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
			c == CH_FF || c == CH_CR;
	endfunction

	function automatic logic is_delim(input logic [CHAR_W-1:0] c);
		return c == CH_SPACE || c == CH_SEMI || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic slcf_res_t byte_res(input logic [CHAR_W-1:0] c, input logic last);
		slcf_res_t r;
		r             = '0;
		r.item_kind   = ITEM_BYTE;
		r.char_out    = c;
		r.last_of_run = last;
		return r;
	endfunction

	assign pos_e     = (!in_tok_q) ? '0 : pos_q;
	assign starting  = !in_tok_q;
	assign name_ch   = cfg.name[{pos_e[3:0], 3'b000} +: CHAR_W];
	assign first_ext = {{LINE_NUMBER_BITS{1'b0}}, cfg.first_line};

	always_comb begin
		at_start_n = at_start_q;
		pslash_n   = pslash_q;
		in_lc_n    = in_lc_q;
		in_bc_n    = in_bc_q;
		star_n     = star_q;
		skip_n     = skip_q;
		tc_n       = tc_q;
		in_tok_n   = in_tok_q;
		pos_n      = pos_q;
		fm_n       = fm_q;
		sm_n       = sm_q;
		lead_n     = lead_q;
		cnt_n      = cnt_q;
		done_n     = done_q;
		num_ext    = '0;
		cls        = LC_CONTENT;
		push       = '0;
		if (step && !done_q) begin
			if (end_of_line) begin
				if (in_tok_q) begin
					if (tc_q == 2'd1 && pos_q != TOKEN_POS_W'(3))
						fm_n = 1'b0;
					if (tc_q == 2'd2 && pos_q != cfg.name_len)
						sm_n = 1'b0;
				end
				if (cnt_q != LINE_MAX)
					cnt_n = cnt_q + 1'b1;
				num_ext = {{LINE_OUT_W{1'b0}}, cnt_n};
				if (tc_q[1] && fm_n && sm_n) begin
					cls    = LC_SECTION_END;
					done_n = 1'b1;
				end else if (at_start_q || skip_q) begin
					cls = LC_SKIPPED;
				end
				push.first.item_kind   = ITEM_SUMMARY;
				push.first.line_class  = cls;
				push.first.line_number = num_ext[LINE_OUT_W-1:0];
				push.first.last_of_run = 1'b1;
				if (pslash_q) begin
					push.second = push.first;
					push.first  = byte_res(CH_SLASH, 1'b0);
					push.count  = 2'd2;
				end else begin
					push.count = 2'd1;
				end
				at_start_n = 1'b1;
				pslash_n   = 1'b0;
				in_lc_n    = 1'b0;
				in_bc_n    = 1'b0;
				star_n     = 1'b0;
				skip_n     = 1'b0;
				tc_n       = '0;
				in_tok_n   = 1'b0;
				pos_n      = '0;
				fm_n       = 1'b1;
				sm_n       = 1'b1;
				lead_n     = 1'b0;
			end else if (!(at_start_q && is_lead_space(ch))) begin
				at_start_n = 1'b0;
				if (at_start_q && (ch == CH_HASH || ch == CH_BANG))
					skip_n = 1'b1;
				if (at_start_q && ch == CH_SLASH)
					lead_n = 1'b1;
				if (is_delim(ch)) begin
					if (in_tok_q) begin
						if (tc_q == 2'd1 && pos_q != TOKEN_POS_W'(3))
							fm_n = 1'b0;
						if (tc_q == 2'd2 && pos_q != cfg.name_len)
							sm_n = 1'b0;
					end
					in_tok_n = 1'b0;
				end else begin
					if (starting && tc_q != 2'd3)
						tc_n = tc_q + 2'd1;
					if (tc_n == 2'd1) begin
						if (!(pos_e < TOKEN_POS_W'(3) && ch == END_WORD[pos_e[1:0]]))
							fm_n = 1'b0;
					end else if (tc_n == 2'd2) begin
						if (!(pos_e < cfg.name_len && ch == name_ch))
							sm_n = 1'b0;
					end
					pos_n    = (pos_e != POS_MAX) ? pos_e + 1'b1 : pos_e;
					in_tok_n = 1'b1;
				end
				if (!skip_n) begin
					if (in_lc_q) begin
						if (ch == CH_LF)
							in_lc_n = 1'b0;
					end else if (in_bc_q) begin
						if (star_q && ch == CH_SLASH) begin
							in_bc_n = 1'b0;
							star_n  = 1'b0;
						end else begin
							star_n = (ch == CH_STAR);
						end
					end else if (pslash_q) begin
						pslash_n = 1'b0;
						if (ch == CH_SLASH) begin
							in_lc_n = 1'b1;
							if (lead_n)
								skip_n = 1'b1;
						end else if (ch == CH_STAR) begin
							in_bc_n = 1'b1;
							star_n  = 1'b0;
						end else begin
							push.first  = byte_res(CH_SLASH, 1'b0);
							push.second = byte_res(ch, 1'b1);
							push.count  = 2'd2;
						end
						lead_n = 1'b0;
					end else if (ch == CH_SLASH) begin
						pslash_n = 1'b1;
					end else begin
						push.first = byte_res(ch, 1'b1);
						push.count = 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			pslash_q   <= 1'b0;
			in_lc_q    <= 1'b0;
			in_bc_q    <= 1'b0;
			star_q     <= 1'b0;
			skip_q     <= 1'b0;
			tc_q       <= '0;
			in_tok_q   <= 1'b0;
			pos_q      <= '0;
			fm_q       <= 1'b1;
			sm_q       <= 1'b1;
			lead_q     <= 1'b0;
			cnt_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			at_start_q <= at_start_n;
			pslash_q   <= pslash_n;
			in_lc_q    <= in_lc_n;
			in_bc_q    <= in_bc_n;
			star_q     <= star_n;
			skip_q     <= skip_n;
			tc_q       <= tc_n;
			in_tok_q   <= in_tok_n;
			pos_q      <= pos_n;
			fm_q       <= fm_n;
			sm_q       <= sm_n;
			lead_q     <= lead_n;
			if (cfg.load_first) begin
				cnt_q  <= first_ext[LINE_NUMBER_BITS-1:0];
				done_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_n;
				done_q <= done_n;
			end
		end
	end

endmodule

// File: design/slcf_result_fifo.sv
// Result queue: takes up to two results a cycle while it has room, returns one a cycle while the sink is ready
`timescale 1ns / 1ps
`include "section_line_comment_filter_core_macros.svh"

module slcf_result_fifo import slcf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  slcf_push_t    push,
	output logic          room,
	slcf_out_if.source    out_res
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	slcf_res_t         mem [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop;
	slcf_res_t         head;

	assign pop  = out_res.valid && out_res.ready;
	assign room = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign head = mem[rd_q];

	assign out_res.valid       = count_q != '0;
	assign out_res.item_kind   = head.item_kind;
	assign out_res.char_out    = head.char_out;
	assign out_res.line_class  = head.line_class;
	assign out_res.line_number = head.line_number;
	assign out_res.last_of_run = head.last_of_run;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem[wr_q] <= push.first;
		if (push.count == 2'd2)
			mem[wr_q + 1'b1] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push.count);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	`SLCF_ASSERT(a_no_overflow, count_q <= CNT_W'(FIFO_DEPTH), "result queue overflow")
	`SLCF_ASSERT(a_push_room, push.count != 2'd0 |-> room, "results pushed without room")
	`SLCF_ASSERT(a_drain, (pop && count_q == CNT_W'(1) && push.count == 2'd0) |=> count_q == '0, "queue not empty after last pop")

endmodule

// File: design/section_line_comment_filter_core.sv
// Top level of the section line comment filter
`timescale 1ns / 1ps

// Strips leading whitespace and C/C++ style comments from a byte stream, one
// request per byte plus one per line end, and gives a summary per line with
// its class and a saturating line number. Requests are taken one per cycle
// while the result queue has room; results are registered in that queue.
// A request that yields two results (a held slash released before a byte or
// before the line summary) leaves the single-result output port one result
// at a time; a four-entry result queue absorbs these and stalls requests
// only when it holds more than two results. After a section end line all
// requests are taken and dropped until first_line_number is written.

module section_line_comment_filter_core import slcf_pkg::*; #(
	parameter int MAX_NAME_BYTES   = 16,
	parameter int LINE_NUMBER_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	slcf_in_if.sink                in_req,
	slcf_out_if.source             out_res,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	logic [CFG_DATA_W-1:0] name_low_q;
	logic [CFG_DATA_W-1:0] name_high_q;
	logic [NAME_LEN_W-1:0] name_len_q;
	slcf_cfg_t             cfg;
	slcf_push_t            push;
	logic                  room;
	logic                  step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_low_q  <= '0;
			name_high_q <= '0;
			name_len_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_e'(cfg_index))
				CFG_NAME_LOW:  name_low_q  <= cfg_wdata;
				CFG_NAME_HIGH: name_high_q <= cfg_wdata;
				CFG_NAME_LEN:  name_len_q  <= cfg_wdata[NAME_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg            = '0;
		cfg.name       = {name_high_q, name_low_q};
		cfg.name_len   = (name_len_q > NAME_LEN_W'(MAX_NAME_BYTES)) ?
			NAME_LEN_W'(MAX_NAME_BYTES) : name_len_q;
		cfg.load_first = cfg_we && cfg_reg_e'(cfg_index) == CFG_FIRST_LINE;
		cfg.first_line = cfg_wdata[LINE_OUT_W-1:0];
	end

	assign in_req.ready = room;
	assign step         = in_req.valid && room;

	slcf_parser #(
		.LINE_NUMBER_BITS(LINE_NUMBER_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.ch         (in_req.ch),
		.end_of_line(in_req.end_of_line),
		.cfg        (cfg),
		.push       (push)
	);

	slcf_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.out_res(out_res)
	);

endmodule
